// ===== design/djs_pkg.sv =====
// Shared types and constants for the deadline job scheduler.
package djs_pkg;

  localparam int DL_W  = 8;
  localparam int PR_W  = 16;
  localparam int SUM_W = 22;
  localparam int CNT_W = 7;

  localparam logic [SUM_W-1:0] PROFIT_MAX = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] COUNT_MAX  = {CNT_W{1'b1}};

  typedef struct packed {
    logic [DL_W-1:0] deadline;
    logic [PR_W-1:0] profit;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } cell_t;

  typedef struct packed {
    logic ins;
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic step;
    logic clear;
  } place_ctrl_t;

endpackage

// ===== design/djs_in_if.sv =====
// Job input channel: valid/ready handshake with one job per beat.
interface djs_in_if;
  logic                      valid;
  logic                      ready;
  logic [djs_pkg::DL_W-1:0]  deadline;
  logic [djs_pkg::PR_W-1:0]  profit;
  logic                      last;

  modport source (output valid, deadline, profit, last, input ready);
  modport sink   (input valid, deadline, profit, last, output ready);
endinterface

// ===== design/djs_out_if.sv =====
// Result channel: valid/ready handshake with one schedule summary per beat.
interface djs_out_if;
  logic                      valid;
  logic                      ready;
  logic [djs_pkg::SUM_W-1:0] total_profit;
  logic [djs_pkg::CNT_W-1:0] jobs_placed;

  modport source (output valid, total_profit, jobs_placed, input ready);
  modport sink   (input valid, total_profit, jobs_placed, output ready);
endinterface

// ===== design/djs_cell.sv =====
// One cell of the profit-sorted job chain.
module djs_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  djs_pkg::cell_ctrl_t ctrl,
  input  djs_pkg::job_t      new_job,
  input  djs_pkg::cell_t     left,
  input  logic               left_g,
  input  djs_pkg::cell_t     right,
  output djs_pkg::cell_t     cur,
  output logic               g
);
  import djs_pkg::*;

  logic valid_r, valid_nxt;
  job_t job_r, job_nxt;

  // The new job goes ahead of this entry only on a strictly higher profit,
  // so equal profits keep arrival order.
  assign g   = valid_r && (new_job.profit > job_r.profit);
  assign cur = '{valid: valid_r, job: job_r};

  always_comb begin
    valid_nxt = valid_r;
    job_nxt   = job_r;
    if (ctrl.clear) begin
      valid_nxt = 1'b0;
    end else if (ctrl.shift) begin
      valid_nxt = right.valid;
      job_nxt   = right.job;
    end else if (ctrl.ins) begin
      if (left_g) begin
        valid_nxt = 1'b1;
        job_nxt   = left.job;
      end else if (g || (!valid_r && left.valid)) begin
        valid_nxt = 1'b1;
        job_nxt   = new_job;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end
endmodule

// ===== design/djs_place.sv =====
// Slot occupancy, latest-free-slot search and profit accumulation.
module djs_place #(
  parameter int MAX_SLOTS = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  djs_pkg::place_ctrl_t      ctrl,
  input  djs_pkg::job_t             job,
  output logic [djs_pkg::SUM_W-1:0] sum,
  output logic [djs_pkg::CNT_W-1:0] placed
);
  import djs_pkg::*;

  logic [MAX_SLOTS-1:0] taken_r, taken_nxt;
  logic [MAX_SLOTS-1:0] pick;
  logic                 found;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [CNT_W-1:0]     placed_r, placed_nxt;
  logic [SUM_W:0]       sum_add;

  // Pick the highest free slot below the deadline; deadlines past the last
  // slot simply cover every slot.
  always_comb begin
    pick  = '0;
    found = 1'b0;
    for (int s = MAX_SLOTS - 1; s >= 0; s--) begin
      if (!found && !taken_r[s] && (s < int'(job.deadline))) begin
        pick[s] = 1'b1;
        found   = 1'b1;
      end
    end
  end

  assign sum_add = {1'b0, sum_r} + (SUM_W + 1)'(job.profit);

  always_comb begin
    taken_nxt  = taken_r;
    sum_nxt    = sum_r;
    placed_nxt = placed_r;
    if (ctrl.clear) begin
      taken_nxt  = '0;
      sum_nxt    = '0;
      placed_nxt = '0;
    end else if (ctrl.step && found) begin
      taken_nxt  = taken_r | pick;
      sum_nxt    = sum_add[SUM_W] ? PROFIT_MAX : sum_add[SUM_W-1:0];
      placed_nxt = (placed_r == COUNT_MAX) ? COUNT_MAX : placed_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r  <= '0;
      sum_r    <= '0;
      placed_r <= '0;
    end else begin
      taken_r  <= taken_nxt;
      sum_r    <= sum_nxt;
      placed_r <= placed_nxt;
    end
  end

  assign sum    = sum_r;
  assign placed = placed_r;
endmodule

// ===== design/deadline_job_scheduler.sv =====
// Top level: jobs load into a sorted cell chain, then drain through slot placement.
// Loading takes one job per cycle in the load state, sorting by profit on the fly.
// After the last beat, placement shifts the chain one job per cycle, and the result
// is registered once the output register is free.
// A new set may load while the previous result waits in the output register.
// Synchronous active-low reset empties the chain, slots, totals and output.
module deadline_job_scheduler #(
  parameter int MAX_JOBS  = 64,
  parameter int MAX_SLOTS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  djs_in_if.sink    in_job,
  djs_out_if.source out_res
);
  import djs_pkg::*;

  localparam int JC_W = $clog2(MAX_JOBS + 1);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_PLACE = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]      state_r, state_nxt;
  logic [JC_W-1:0] count_r, count_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0] out_sum_r;
  logic [CNT_W-1:0] out_cnt_r;

  cell_t       cells [MAX_JOBS];
  logic        gs    [MAX_JOBS];
  cell_ctrl_t  cctrl;
  place_ctrl_t pctrl;
  job_t        new_job;
  logic        beat, full, emit;
  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] placed;

  assign new_job = '{deadline: in_job.deadline, profit: in_job.profit};
  assign full    = (count_r == JC_W'(MAX_JOBS));
  assign in_job.ready = (state_r == ST_LOAD);
  assign beat    = in_job.valid && in_job.ready;
  assign emit    = (state_r == ST_FLUSH) && (!out_valid_r || out_res.ready);

  always_comb begin
    cctrl.ins   = beat && !full;
    cctrl.shift = (state_r == ST_PLACE) && cells[0].valid;
    cctrl.clear = emit;
    pctrl.step  = cctrl.shift;
    pctrl.clear = emit;
  end

  for (genvar i = 0; i < MAX_JOBS; i++) begin : g_chain
    cell_t left_c, right_c;
    logic  left_g;
    if (i == 0) begin : g_head
      assign left_c = '{valid: 1'b1, job: '0};
      assign left_g = 1'b0;
    end else begin : g_mid
      assign left_c = cells[i-1];
      assign left_g = gs[i-1];
    end
    if (i == MAX_JOBS - 1) begin : g_tail
      assign right_c = '{valid: 1'b0, job: '0};
    end else begin : g_body
      assign right_c = cells[i+1];
    end
    djs_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (cctrl),
      .new_job (new_job),
      .left    (left_c),
      .left_g  (left_g),
      .right   (right_c),
      .cur     (cells[i]),
      .g       (gs[i])
    );
  end

  djs_place #(.MAX_SLOTS(MAX_SLOTS)) u_place (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (pctrl),
    .job    (cells[0].job),
    .sum    (sum),
    .placed (placed)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_LOAD: begin
        if (cctrl.ins) begin
          count_nxt = count_r + 1'b1;
        end
        if (beat && in_job.last) begin
          state_nxt = ST_PLACE;
        end
      end
      ST_PLACE: begin
        // The chain empties from the head; an empty head ends the pass.
        if (!cells[0].valid) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (emit) begin
          out_valid_nxt = 1'b1;
          count_nxt     = '0;
          state_nxt     = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_sum_r <= sum;
      out_cnt_r <= placed;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.total_profit = out_sum_r;
  assign out_res.jobs_placed  = out_cnt_r;
endmodule

// ===== tb/deadline_job_scheduler_test.sv =====
// Self-checking testbench for the deadline job scheduler.
`timescale 1ns / 1ps

module deadline_job_scheduler_test;
  import djs_pkg::*;

  localparam int MAX_JOBS     = 64;
  localparam int MAX_SLOTS    = 64;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_JOBS  = 800;

  typedef struct packed {
    logic [SUM_W-1:0] total_profit;
    logic [CNT_W-1:0] jobs_placed;
  } schedule_t;

  logic clk;
  logic rst_n;

  djs_in_if  job_ch ();
  djs_out_if res_ch ();

  deadline_job_scheduler #(
    .MAX_JOBS (MAX_JOBS),
    .MAX_SLOTS(MAX_SLOTS)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_job (job_ch),
    .out_res(res_ch)
  );

  // Jobs of the set being loaded, kept in profit order, highest first.
  job_t      pending_jobs[$];
  schedule_t expected_schedules[$];

  int  error_count;
  int  jobs_sent;
  int  schedules_checked;
  bit  tx_steady;
  bit  rx_steady;
  int  hold_off_left;
  int  rx_stall_left;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(0, 2);
    if (roll < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // Greedy placement: each job, by profit, takes the latest free slot before its deadline.
  function automatic schedule_t schedule_pending();
    logic [MAX_SLOTS-1:0] busy;
    int                   slot;
    int                   sum;
    int                   placed;
    schedule_t            res;
    busy   = '0;
    sum    = 0;
    placed = 0;
    foreach (pending_jobs[i]) begin
      slot = (pending_jobs[i].deadline > MAX_SLOTS) ? MAX_SLOTS : pending_jobs[i].deadline;
      while (slot > 0) begin
        slot--;
        if (!busy[slot]) begin
          busy[slot] = 1'b1;
          sum = sum + pending_jobs[i].profit;
          if (sum > PROFIT_MAX) sum = int'(PROFIT_MAX);
          if (placed < COUNT_MAX) placed++;
          break;
        end
      end
    end
    res.total_profit = sum[SUM_W-1:0];
    res.jobs_placed  = placed[CNT_W-1:0];
    return res;
  endfunction

  function automatic void record_job(job_t job, logic last);
    int pos;
    jobs_sent++;
    // Jobs that arrive with the store full are dropped, but their last flag still counts.
    if (pending_jobs.size() < MAX_JOBS) begin
      pos = 0;
      while (pos < pending_jobs.size() && pending_jobs[pos].profit >= job.profit) pos++;
      pending_jobs.insert(pos, job);
    end
    if (last) begin
      expected_schedules.push_back(schedule_pending());
      pending_jobs.delete();
    end
  endfunction

  task automatic send_job(input logic [DL_W-1:0] deadline, input logic [PR_W-1:0] profit,
                          input logic last);
    int   gap;
    job_t job;
    gap = tx_steady ? 0 : ($urandom_range(0, 1) ? 0 : pick_gap());
    repeat (gap) begin
      @(negedge clk);
      job_ch.valid    <= 1'b0;
      job_ch.deadline <= DL_W'($urandom);
      job_ch.profit   <= PR_W'($urandom);
      job_ch.last     <= 1'($urandom);
    end
    @(negedge clk);
    job_ch.valid    <= 1'b1;
    job_ch.deadline <= deadline;
    job_ch.profit   <= profit;
    job_ch.last     <= last;
    @(posedge clk);
    while (!job_ch.ready) @(posedge clk);
    job.deadline = deadline;
    job.profit   = profit;
    record_job(job, last);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    job_ch.valid <= 1'b0;
    while (expected_schedules.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_random_set(input int n_jobs);
    int              dl_hi;
    bit              ties;
    logic [DL_W-1:0] deadline;
    logic [PR_W-1:0] profit;
    case ($urandom_range(0, 3))
      0: dl_hi = n_jobs / 2 + 1;
      1: dl_hi = n_jobs;
      2: dl_hi = MAX_SLOTS;
      default: dl_hi = 255;
    endcase
    if (dl_hi > 255) dl_hi = 255;
    ties = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n_jobs; i++) begin
      deadline = ($urandom_range(0, 15) == 0) ? DL_W'($urandom_range(0, 255))
                                              : DL_W'($urandom_range(0, dl_hi));
      case ($urandom_range(0, 19))
        0: profit = '0;
        1: profit = '1;
        default: profit = ties ? PR_W'($urandom_range(0, 3) * 1000)
                               : PR_W'($urandom_range(0, 65535));
      endcase
      send_job(deadline, profit, i == n_jobs - 1);
    end
  endtask

  task automatic test_directed();
    // A zero deadline is never placed, even with the highest profit.
    send_job(8'd0, 16'hFFFF, 1'b1);
    // A deadline far beyond the slot count saturates.
    send_job(8'd255, 16'hFFFF, 1'b1);
    // A zero-profit job still takes a slot.
    send_job(8'd1, 16'd0, 1'b1);
    // Equal profits competing for the same slots.
    send_job(8'd1, 16'd100, 1'b0);
    send_job(8'd2, 16'd100, 1'b0);
    send_job(8'd2, 16'd100, 1'b1);
    // Textbook set where lower-profit jobs lose their slots.
    send_job(8'd2, 16'd100, 1'b0);
    send_job(8'd1, 16'd19,  1'b0);
    send_job(8'd2, 16'd27,  1'b0);
    send_job(8'd1, 16'd25,  1'b0);
    send_job(8'd3, 16'd15,  1'b1);
    // Deadlines around the slot count.
    send_job(8'd64,  16'd1, 1'b0);
    send_job(8'd65,  16'd2, 1'b0);
    send_job(8'd128, 16'd3, 1'b1);
    // Alternating bit patterns.
    send_job(8'hAA, 16'h5555, 1'b0);
    send_job(8'h55, 16'hAAAA, 1'b1);
    wait_drained();
  endtask

  task automatic test_full_store();
    // Every job at maximum profit with a far deadline gives the largest total.
    for (int i = 0; i < MAX_JOBS; i++) send_job(8'd255, 16'hFFFF, 1'b0);
    // Two extra jobs are dropped; the second one still closes the set.
    send_job(8'd1, 16'hFFFF, 1'b0);
    send_job(8'd1, 16'hFFFF, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_sets();
    int roll;
    int n_jobs;
    int set_idx;
    set_idx = 0;
    while (jobs_sent < RANDOM_JOBS) begin
      // A stretch of back-to-back traffic on both sides, with random idling around it.
      tx_steady = (set_idx >= 10 && set_idx < 18);
      rx_steady = (set_idx >= 12 && set_idx < 20);
      roll = $urandom_range(0, 99);
      if (roll < 70)      n_jobs = $urandom_range(1, 12);
      else if (roll < 95) n_jobs = $urandom_range(13, 40);
      else if (roll < 99) n_jobs = $urandom_range(41, MAX_JOBS);
      else                n_jobs = $urandom_range(MAX_JOBS + 1, MAX_JOBS + 6);
      send_random_set(n_jobs);
      set_idx++;
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    wait_drained();
  endtask

  task automatic test_output_hold_off();
    // The result side stays blocked while three sets are offered back to back.
    hold_off_left = 500;
    tx_steady     = 1'b1;
    repeat (3) send_random_set(30);
    tx_steady = 1'b0;
    wait_drained();
  endtask

  // Result side ready pattern, including the long hold-off.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_off_left--;
      end else if (rx_steady) begin
        res_ch.ready <= 1'b1;
      end else if (rx_stall_left > 0) begin
        res_ch.ready <= 1'b0;
        rx_stall_left--;
      end else if ($urandom_range(0, 3) == 0) begin
        rx_stall_left = pick_gap();
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    schedule_t exp_res;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (expected_schedules.size() == 0) begin
        $error("result beat with no schedule expected: total_profit %0d, jobs_placed %0d",
               res_ch.total_profit, res_ch.jobs_placed);
        error_count++;
      end else begin
        exp_res = expected_schedules.pop_front();
        schedules_checked++;
        if (res_ch.total_profit !== exp_res.total_profit) begin
          $error("total_profit: expected %0d, got %0d", exp_res.total_profit,
                 res_ch.total_profit);
          error_count++;
        end
        if (res_ch.jobs_placed !== exp_res.jobs_placed) begin
          $error("jobs_placed: expected %0d, got %0d", exp_res.jobs_placed,
                 res_ch.jobs_placed);
          error_count++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("Timeout waiting for results");
    $display("Some tests failed");
    $finish;
  end

  initial begin
    error_count       = 0;
    jobs_sent         = 0;
    schedules_checked = 0;
    tx_steady         = 1'b0;
    rx_steady         = 1'b0;
    hold_off_left     = 0;
    rx_stall_left     = 0;
    rst_n             = 1'b0;
    job_ch.valid      = 1'b0;
    job_ch.deadline   = '0;
    job_ch.profit     = '0;
    job_ch.last       = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_full_store();
    test_random_sets();
    test_output_hold_off();

    $display("Checked %0d schedules built from %0d jobs, covering edge deadlines and profits,",
             schedules_checked, jobs_sent);
    $display("overfull job sets, random idling on both sides and a long result-side stall.");
    if (error_count == 0 && expected_schedules.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/djs_pkg.sv
design/djs_in_if.sv
design/djs_out_if.sv
design/djs_cell.sv
design/djs_place.sv
design/deadline_job_scheduler.sv
tb/deadline_job_scheduler_test.sv
